>>> hw/rtl/csled_pkg.sv
`timescale 1ns / 1ps
package csled_pkg;

    // sample and ratio formats
    localparam int SAMPLE_BITS = 16;
    localparam int IN_W        = 16;
    localparam int FRAC_BITS   = 4;
    localparam int RATIO_BITS  = 8 + FRAC_BITS;
    localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};

    // divider: two quotient bits per step
    localparam int DIV_STEPS = (RATIO_BITS + 1) / 2;
    localparam int DIV_BITS  = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // color channels
    localparam int NUM_CH = 3;
    localparam int CH_W   = 2;
    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    // configuration registers
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int THR_W       = 8;
    localparam int GAIN_W      = 6;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_EIGHTHS     = 2'd1;
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd20;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 6'd20;

    // led drive
    localparam int LED_W  = 8;
    localparam int PROD_W = LED_W + GAIN_W;
    localparam int GAIN_SHIFT = 3;

    typedef logic [LED_W-1:0] gamma_table_t [256];

    // gamma 2.5 curve: largest v with v^2 * 255^3 <= i^5
    function automatic gamma_table_t build_gamma();
        gamma_table_t    t;
        longint unsigned k;
        longint unsigned v;
        longint unsigned p;
        longint unsigned ii;
        k = 64'd255 * 64'd255 * 64'd255;
        v = 0;
        for (int i = 0; i < 256; i++) begin
            ii = longint'(i);
            p  = ii * ii * ii * ii * ii;
            while (v < 64'd255 && (v + 1) * (v + 1) * k <= p) begin
                v = v + 1;
            end
            t[i] = v[LED_W-1:0];
        end
        return t;
    endfunction

    localparam gamma_table_t GAMMA_ROM = build_gamma();

    // controller to datapath commands
    typedef struct packed {
        logic            capture;
        logic            div_init;
        logic            div_step;
        logic            div_last;
        logic            update_last;
        logic            mul;
        logic            out_load;
        logic [CH_W-1:0] ch_sel;
    } csled_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic moved;
    } csled_status_t;

endpackage

>>> hw/rtl/csled_ctrl.sv
`timescale 1ns / 1ps
module csled_ctrl
    import csled_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  csled_status_t status,
    output csled_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              last_step;

    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.ch_sel   = ch_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    ch_next     = CH_RED;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step) begin
                    cmd.div_last = 1'b1;
                    if (ch_reg == CH_BLUE) begin
                        state_next = ST_CMP;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_CMP: begin
                if (status.moved) begin
                    cmd.update_last = 1'b1;
                    state_next      = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= CH_RED;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hw/rtl/csled_dpath.sv
`timescale 1ns / 1ps
module csled_dpath
    import csled_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [IN_W-1:0]        s_red_count,
    input  logic [IN_W-1:0]        s_green_count,
    input  logic [IN_W-1:0]        s_blue_count,
    input  logic [IN_W-1:0]        s_clear_count,
    input  csled_cmd_t             cmd,
    output csled_status_t          status,
    output logic [LED_W-1:0]       m_led_red,
    output logic [LED_W-1:0]       m_led_green,
    output logic [LED_W-1:0]       m_led_blue
);

    logic [THR_W-1:0]       thr_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [SAMPLE_BITS-1:0] ch_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] clr_reg;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0]    quo_reg, quo_next;
    logic                   sat_reg;
    logic [RATIO_BITS-1:0]  ratio_reg [NUM_CH];
    logic [RATIO_BITS-1:0]  last_reg [NUM_CH];
    logic [PROD_W-1:0]      prod_reg [NUM_CH];
    logic [LED_W-1:0]       led_reg [NUM_CH];
    logic [LED_W-1:0]       led_next [NUM_CH];
    logic [SAMPLE_BITS-1:0] ch_cur;
    logic [SAMPLE_BITS:0]   t1, t2, r1, r2;
    logic                   ge1, ge2;
    logic [RATIO_BITS-1:0]  ratio_new;
    logic [RATIO_BITS-1:0]  lim;
    logic [NUM_CH-1:0]      ch_moved;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_RESET;
            gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CHANGE_THRESHOLD: thr_reg  <= cfg_wr_data[THR_W-1:0];
                REG_GAIN_EIGHTHS:     gain_reg <= cfg_wr_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sample capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg[0] <= s_red_count[SAMPLE_BITS-1:0];
            ch_reg[1] <= s_green_count[SAMPLE_BITS-1:0];
            ch_reg[2] <= s_blue_count[SAMPLE_BITS-1:0];
            clr_reg   <= s_clear_count[SAMPLE_BITS-1:0];
        end
    end

    // channel under division
    always_comb begin
        case (cmd.ch_sel)
            CH_RED:   ch_cur = ch_reg[0];
            CH_GREEN: ch_cur = ch_reg[1];
            CH_BLUE:  ch_cur = ch_reg[2];
            default:  ch_cur = ch_reg[0];
        endcase
    end

    // radix-4 restoring step, remainder stays below the clear count unless saturated
    always_comb begin
        t1       = {rem_reg, 1'b0};
        ge1      = (t1 >= {1'b0, clr_reg});
        r1       = ge1 ? (t1 - {1'b0, clr_reg}) : t1;
        t2       = {r1[SAMPLE_BITS-1:0], 1'b0};
        ge2      = (t2 >= {1'b0, clr_reg});
        r2       = ge2 ? (t2 - {1'b0, clr_reg}) : t2;
        rem_next = r2[SAMPLE_BITS-1:0];
        quo_next = {quo_reg[DIV_BITS-3:0], ge1, ge2};
        ratio_new = sat_reg ? RATIO_MAX : quo_next[DIV_BITS-1 -: RATIO_BITS];
    end

    // divider registers; zero clear or channel at or above clear saturates
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= ch_cur;
            quo_reg <= '0;
            sat_reg <= (clr_reg == '0) || (ch_cur >= clr_reg);
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_last) begin
            case (cmd.ch_sel)
                CH_RED:   ratio_reg[0] <= ratio_new;
                CH_GREEN: ratio_reg[1] <= ratio_new;
                CH_BLUE:  ratio_reg[2] <= ratio_new;
                default: begin
                end
            endcase
        end
    end

    // change detection against the last shown color
    assign lim = RATIO_BITS'(thr_reg) << FRAC_BITS;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (ratio_reg[i] >= last_reg[i]) begin
                ch_moved[i] = (ratio_reg[i] - last_reg[i]) > lim;
            end else begin
                ch_moved[i] = (last_reg[i] - ratio_reg[i]) > lim;
            end
        end
    end

    assign status.moved = |ch_moved;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) begin
                last_reg[i] <= '0;
            end
        end else if (cmd.update_last) begin
            for (int i = 0; i < NUM_CH; i++) begin
                last_reg[i] <= ratio_reg[i];
            end
        end
    end

    // gamma lookup times gain
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            for (int i = 0; i < NUM_CH; i++) begin
                prod_reg[i] <= PROD_W'(GAMMA_ROM[ratio_reg[i][RATIO_BITS-1:FRAC_BITS]])
                               * PROD_W'(gain_reg);
            end
        end
    end

    // scale by one eighth and saturate
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (prod_reg[i][PROD_W-1:GAIN_SHIFT] > (PROD_W-GAIN_SHIFT)'(255)) begin
                led_next[i] = '1;
            end else begin
                led_next[i] = prod_reg[i][GAIN_SHIFT +: LED_W];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            for (int i = 0; i < NUM_CH; i++) begin
                led_reg[i] <= led_next[i];
            end
        end
    end

    assign m_led_red   = led_reg[0];
    assign m_led_green = led_reg[1];
    assign m_led_blue  = led_reg[2];

endmodule

>>> hw/rtl/color_sensor_to_led_tracker_core.sv
`timescale 1ns / 1ps
// sequence: each channel in turn gets a divider init and its divide steps; then compare,
//   multiply and output load follow; one shared radix-4 divider serves all channels
// one sample at a time; with no result, multiply and output load are skipped
// a result may wait in the output register while the next sample is taken
// reset: synchronous active-low aresetn; threshold and gain return to 20, last color to 0
module color_sensor_to_led_tracker_core
    import csled_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [IN_W-1:0]        s_red_count,
    input  logic [IN_W-1:0]        s_green_count,
    input  logic [IN_W-1:0]        s_blue_count,
    input  logic [IN_W-1:0]        s_clear_count,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LED_W-1:0]       m_led_red,
    output logic [LED_W-1:0]       m_led_green,
    output logic [LED_W-1:0]       m_led_blue
);

    csled_cmd_t    cmd;
    csled_status_t status;

    // sequencer
    csled_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // divider, compare, gamma and output registers
    csled_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_red_count   (s_red_count),
        .s_green_count (s_green_count),
        .s_blue_count  (s_blue_count),
        .s_clear_count (s_clear_count),
        .cmd           (cmd),
        .status        (status),
        .m_led_red     (m_led_red),
        .m_led_green   (m_led_green),
        .m_led_blue    (m_led_blue)
    );

endmodule

>>> hw/rtl/csled_checker.sv
`timescale 1ns / 1ps
module csled_checker
    import csled_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [LED_W-1:0] m_led_red,
    input logic [LED_W-1:0] m_led_green,
    input logic [LED_W-1:0] m_led_blue
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_red) && $stable(m_led_green)
            && $stable(m_led_blue))
        else $error("result changed while stalled");

    // result channel is empty after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // one sample in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // a result never appears right after a sample is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("result too early");

endmodule

bind color_sensor_to_led_tracker_core csled_checker u_csled_checker (.*);
